// ----- design/assert_macros.svh -----
// Assertion macros shared by the radix digit converter RTL.
// Pulled in by `include; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RDC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication check failed");
`define RDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define RDC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- design/rdc_pkg.sv -----
// Shared types, constants and helpers for the radix digit converter.
// No dependencies.
`default_nettype none
package rdc_pkg;

  localparam int DEF_VALUE_BITS = 31;
  localparam int DEF_MAX_DIGITS = 32;
  localparam int DIGIT_W        = 6;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  localparam logic [DIGIT_W-1:0] BASE_RESET = 6'd2;
  localparam logic [DIGIT_W-1:0] BASE_MIN   = 6'd2;
  localparam logic               REG_BASE   = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_POP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic push;
    logic rd;
  } stk_ctl_t;

  function automatic logic [DIGIT_W-1:0] eff_radix(input logic [DIGIT_W-1:0] b);
    eff_radix = (b < BASE_MIN) ? BASE_MIN : b;
  endfunction

endpackage
`default_nettype wire

// ----- design/rdc_divider.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on rdc_pkg.
`default_nettype none
module rdc_divider #(
  parameter int VALUE_BITS = rdc_pkg::DEF_VALUE_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       load,
  input  wire logic [VALUE_BITS-1:0]      dividend,
  input  wire logic [rdc_pkg::DIGIT_W-1:0] divisor,
  output logic                            done,
  output logic [VALUE_BITS-1:0]           quotient,
  output logic [rdc_pkg::DIGIT_W-1:0]     remainder
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam int DW    = rdc_pkg::DIGIT_W;

  logic [VALUE_BITS-1:0] work_r, work_nxt;
  logic [DW-1:0]         rem_r, rem_nxt;
  logic [DW-1:0]         dvs_r;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic [DW:0]           trial;
  logic                  qbit;

  always_comb begin
    trial    = {rem_r, work_r[VALUE_BITS-1]};
    qbit     = (trial >= {1'b0, dvs_r});
    rem_nxt  = rem_r;
    work_nxt = work_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (load) begin
      work_nxt = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(VALUE_BITS);
    end else if (cnt_r != '0) begin
      rem_nxt  = qbit ? DW'(trial - {1'b0, dvs_r}) : trial[DW-1:0];
      work_nxt = {work_r[VALUE_BITS-2:0], qbit};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    if (load) begin
      dvs_r <= divisor;
    end
  end

  assign done      = done_r;
  assign quotient  = work_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

// ----- design/rdc_digit_stack.sv -----
// Digit stack memory: one write port, one registered read port.
// Depends on rdc_pkg.
`default_nettype none
module rdc_digit_stack #(
  parameter int MAX_DIGITS = rdc_pkg::DEF_MAX_DIGITS
) (
  input  wire logic                          clk,
  input  wire rdc_pkg::stk_ctl_t             ctl,
  input  wire logic [$clog2(MAX_DIGITS)-1:0] addr,
  input  wire logic [rdc_pkg::DIGIT_W-1:0]   wr_data,
  output logic      [rdc_pkg::DIGIT_W-1:0]   rd_data
);

  logic [rdc_pkg::DIGIT_W-1:0] mem [MAX_DIGITS];
  logic [rdc_pkg::DIGIT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[addr] <= wr_data;
    end
    if (ctl.rd) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- design/radix_digit_converter_top.sv -----
// Radix digit converter top: control FSM, APB register, divider and stack.
// Depends on rdc_pkg, rdc_divider, rdc_digit_stack, assert_macros.svh.
//
// Converts in_value to base-N digits and emits them most significant first,
// one digit per out_strobe pulse, out_last on the final digit; a zero input
// gives no output. The receiver cannot stall: each digit is shown for exactly
// one cycle. Each digit costs one full pass of the bit-serial divider, then
// draining the stack takes a read state and an output state per digit.
// busy stays high for the whole conversion.
`default_nettype none
`include "assert_macros.svh"
module radix_digit_converter_top #(
  parameter int VALUE_BITS = rdc_pkg::DEF_VALUE_BITS,
  parameter int MAX_DIGITS = rdc_pkg::DEF_MAX_DIGITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [VALUE_BITS-1:0]            in_value,
  output logic                                  out_strobe,
  output logic [rdc_pkg::DIGIT_W-1:0]           out_digit,
  output logic                                  out_last,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [rdc_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [rdc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rdc_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready
);

  localparam int DEPTH_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W   = $clog2(MAX_DIGITS);
  localparam int DW      = rdc_pkg::DIGIT_W;
  localparam int PAD_W   = rdc_pkg::APB_DATA_W - DW;

  rdc_pkg::state_t   state_r, state_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt, depth_dec;
  logic [DW-1:0]      base_r;
  logic [DW-1:0]      divisor_r, divisor_nxt;
  logic               cfg_wr;

  logic                  div_load;
  logic [VALUE_BITS-1:0] div_dividend;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [DW-1:0]         div_rem;

  rdc_pkg::stk_ctl_t stk_ctl;
  logic [IDX_W-1:0]  stk_addr;
  logic [DW-1:0]     stk_rd_data;

  // APB register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == rdc_pkg::REG_BASE);
  assign prdata = (paddr[2] == rdc_pkg::REG_BASE) ? {{PAD_W{1'b0}}, base_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= rdc_pkg::BASE_RESET;
    end else if (cfg_wr) begin
      base_r <= pwdata[DW-1:0];
    end
  end

  // Control FSM
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rdc_pkg::ST_IDLE;
      depth_r <= '0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
    end
    divisor_r <= divisor_nxt;
  end

  assign depth_dec = depth_r - DEPTH_W'(1);

  always_comb begin
    state_nxt    = state_r;
    depth_nxt    = depth_r;
    divisor_nxt  = divisor_r;
    div_load     = 1'b0;
    div_dividend = in_value;
    stk_ctl      = '0;
    stk_addr     = depth_r[IDX_W-1:0];
    unique case (state_r)
      rdc_pkg::ST_IDLE: begin
        if (start && (in_value != '0)) begin
          div_load    = 1'b1;
          divisor_nxt = rdc_pkg::eff_radix(base_r);
          depth_nxt   = '0;
          state_nxt   = rdc_pkg::ST_DIV;
        end
      end
      rdc_pkg::ST_DIV: begin
        if (div_done) begin
          stk_ctl.push = 1'b1;
          depth_nxt    = depth_r + DEPTH_W'(1);
          if ((div_quot != '0) && (depth_r != DEPTH_W'(MAX_DIGITS - 1))) begin
            div_load     = 1'b1;
            div_dividend = div_quot;
          end else begin
            state_nxt = rdc_pkg::ST_POP;
          end
        end
      end
      rdc_pkg::ST_POP: begin
        stk_ctl.rd = 1'b1;
        stk_addr   = depth_dec[IDX_W-1:0];
        depth_nxt  = depth_dec;
        state_nxt  = rdc_pkg::ST_EMIT;
      end
      rdc_pkg::ST_EMIT: begin
        state_nxt = (depth_r == '0) ? rdc_pkg::ST_IDLE : rdc_pkg::ST_POP;
      end
      default: begin
        state_nxt = rdc_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != rdc_pkg::ST_IDLE);
  assign out_strobe = (state_r == rdc_pkg::ST_EMIT);
  assign out_digit  = stk_rd_data;
  assign out_last   = (depth_r == '0);

  rdc_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (div_load),
    .dividend (div_dividend),
    .divisor  (divisor_nxt),
    .done     (div_done),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  rdc_digit_stack #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_stk (
    .clk    (clk),
    .ctl    (stk_ctl),
    .addr   (stk_addr),
    .wr_data(div_rem),
    .rd_data(stk_rd_data)
  );

  `RDC_ASSERT_NEXT(a_last_ends_run, clk, rst_n, out_strobe && out_last, !busy)
  `RDC_ASSERT_NEXT(a_zero_no_run, clk, rst_n, start && !busy && (in_value == '0), !busy)
  `RDC_ASSERT_IMPL(a_digit_below_radix, clk, rst_n, out_strobe, out_digit < divisor_r)
  `RDC_ASSERT_IMPL(a_div_done_in_div, clk, rst_n, div_done, state_r == rdc_pkg::ST_DIV)
  `RDC_ASSERT_IMPL(a_depth_bound, clk, rst_n, busy, depth_r <= DEPTH_W'(MAX_DIGITS))

endmodule
`default_nettype wire
